FILE: rtl/tcpq_pkg.sv
// Shared types and codes for the two-class priority queue.
// No dependencies; used by tcpq_store and two_class_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

    // Fixed widths of the port fields
    localparam int TAG_PORT_W = 32;
    localparam int CNT_PORT_W = 5;
    localparam int POS_PORT_W = 5;

    // Request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_NO_POS = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // One request word
    typedef struct packed {
        logic [1:0]            req_type;
        logic [TAG_PORT_W-1:0] entry_tag;
        logic                  is_priority;
        logic [POS_PORT_W-1:0] position;
    } t_req;

    // One result word
    typedef struct packed {
        logic [1:0]            status;
        logic [TAG_PORT_W-1:0] popped_tag;
        logic [CNT_PORT_W-1:0] entry_count;
        logic [CNT_PORT_W-1:0] priority_count;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/tcpq_store.sv
// Shift-capable entry array with entry and priority counts.
// Computes one request's result in the same cycle; depends on tcpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpq_store #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_en,
    input  wire tcpq_pkg::t_req   i_req,
    output tcpq_pkg::t_result     o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > tcpq_pkg::POS_PORT_W) ? CW : tcpq_pkg::POS_PORT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [TAG_WIDTH-1:0] r_entry [DEPTH];
    logic [TAG_WIDTH-1:0] n_entry [DEPTH];
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_prio, n_prio;
    logic                 n_we;

    logic [TAG_WIDTH-1:0] add_tag;
    logic [CW-1:0]        add_slot;
    logic [CW-1:0]        rm_slot;
    logic [PW-1:0]        pos_ext;
    logic [PW-1:0]        cnt_ext;

    assign add_tag  = TAG_WIDTH'(i_req.entry_tag);
    assign add_slot = i_req.is_priority ? r_prio : r_count;
    assign pos_ext  = PW'(i_req.position);
    assign cnt_ext  = PW'(r_count);
    assign rm_slot  = CW'(pos_ext - PW'(1));

    // Next state and result for the presented request
    always_comb begin
        n_entry  = r_entry;
        n_count  = r_count;
        n_prio   = r_prio;
        n_we     = 1'b0;
        o_result = '0;
        o_result.status = tcpq_pkg::STAT_OK;
        case (i_req.req_type)
            tcpq_pkg::REQ_ADD: begin
                if (r_count == FULL_COUNT) begin
                    o_result.status = tcpq_pkg::STAT_FULL;
                end else begin
                    n_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    if (i_req.is_priority) begin
                        n_prio = r_prio + CW'(1);
                    end
                    // open a gap at the slot, entries behind it move back one
                    for (int k = 0; k < DEPTH; k++) begin
                        if (CW'(k) == add_slot) begin
                            n_entry[k] = add_tag;
                        end else if (k > 0 && CW'(k) > add_slot && CW'(k) <= r_count) begin
                            n_entry[k] = r_entry[(k > 0) ? k - 1 : 0];
                        end
                    end
                end
            end
            tcpq_pkg::REQ_POP: begin
                if (r_count == '0) begin
                    o_result.status = tcpq_pkg::STAT_EMPTY;
                end else begin
                    n_we    = 1'b1;
                    n_count = r_count - CW'(1);
                    o_result.popped_tag = tcpq_pkg::TAG_PORT_W'(r_entry[0]);
                    if (r_prio != '0) begin
                        n_prio = r_prio - CW'(1);
                    end
                    // everything moves forward one
                    for (int k = 0; k < DEPTH; k++) begin
                        if (k + 1 < DEPTH) begin
                            n_entry[k] = r_entry[(k + 1 < DEPTH) ? k + 1 : k];
                        end
                    end
                end
            end
            tcpq_pkg::REQ_REMOVE: begin
                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    o_result.status = tcpq_pkg::STAT_NO_POS;
                end else begin
                    n_we    = 1'b1;
                    n_count = r_count - CW'(1);
                    if (rm_slot < r_prio) begin
                        n_prio = r_prio - CW'(1);
                    end
                    // close the gap at the removed slot
                    for (int k = 0; k < DEPTH; k++) begin
                        if (k + 1 < DEPTH && CW'(k) >= rm_slot) begin
                            n_entry[k] = r_entry[(k + 1 < DEPTH) ? k + 1 : k];
                        end
                    end
                end
            end
            default: begin
                // unused code: no change, status ok
            end
        endcase
        o_result.entry_count    = tcpq_pkg::CNT_PORT_W'(n_count);
        o_result.priority_count = tcpq_pkg::CNT_PORT_W'(n_prio);
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prio  <= '0;
        end else if (i_req_en) begin
            r_count <= n_count;
            r_prio  <= n_prio;
        end
    end

    // Entry array, no reset
    always_ff @(posedge i_clk) begin
        if (i_req_en && n_we) begin
            r_entry <= n_entry;
        end
    end

    // Checks
    a_prio_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prio <= r_count)
        else $error("priority count exceeds entry count");

    a_count_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count exceeds depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_en && i_req.req_type == tcpq_pkg::REQ_POP && r_count != '0
        |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not drop entry count");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_en && i_req.req_type == tcpq_pkg::REQ_ADD && r_count == FULL_COUNT
        |=> r_count == FULL_COUNT && $stable(r_prio))
        else $error("add to full store changed counts");

endmodule

`default_nettype wire

FILE: rtl/two_class_priority_queue.sv
// Two-class priority queue top level: request channel, store, result skid.
// Depends on tcpq_pkg and tcpq_store.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries add, pop or remove
//   words; a word is taken at a clock edge with i_in_valid high and
//   o_in_stall low. Every request gives exactly one result word on the
//   result channel (o_out_valid / i_out_stall), in request order.
//   The result is registered into the output register, or into the skid
//   register while the output stalls. Throughput: one request per cycle
//   while o_in_stall is low; the shift array and counts update when taken.
//   Priority adds land behind held priority entries, normal adds at the
//   tail; pop takes the head, remove closes the gap at a 1-based position.
//   When the receiver stalls, the output register holds its word and one
//   more result goes into a skid register; only then o_in_stall rises,
//   and it falls once the skid word moves to the output register.
//   Reset (synchronous, active low) empties the queue and drops any
//   pending result; the tag storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_entry_tag,
    input  wire logic        i_is_priority,
    input  wire logic [4:0]  i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_popped_tag,
    output logic [4:0]       o_entry_count,
    output logic [4:0]       o_priority_count
);

    tcpq_pkg::t_req    req;
    tcpq_pkg::t_result result;
    logic              in_acc;

    logic              r_out_valid;
    logic              r_skid_valid;
    tcpq_pkg::t_result r_out;
    tcpq_pkg::t_result r_skid;
    logic              out_free;

    assign req.req_type    = i_req_type;
    assign req.entry_tag   = i_entry_tag;
    assign req.is_priority = i_is_priority;
    assign req.position    = i_position;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    tcpq_store #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_en (in_acc),
        .i_req    (req),
        .o_result (result)
    );

    // Output register and skid valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result words
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_acc) begin
            r_skid <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_popped_tag     = r_out.popped_tag;
    assign o_entry_count    = r_out.entry_count;
    assign o_priority_count = r_out.priority_count;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(i_out_stall) && $past(r_out_valid))
        else $error("skid filled without a stalled output");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for two_class_priority_queue: directed and random request words.
// Depends on tcpq_pkg and the RTL of two_class_priority_queue; a shadow queue predicts results.
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_REQS = 1300;
    localparam int DRAIN_LIMIT = 20000;
    // Request code 3 is unused by the block and must be ignored
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = tcpq_pkg::REQ_ADD;
    logic [31:0] i_entry_tag = '0;
    logic        i_is_priority = 1'b0;
    logic [4:0]  i_position = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [31:0] o_popped_tag;
    logic [4:0]  o_entry_count;
    logic [4:0]  o_priority_count;

    two_class_priority_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .TAG_WIDTH (32)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_entry_tag      (i_entry_tag),
        .i_is_priority    (i_is_priority),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_popped_tag     (o_popped_tag),
        .o_entry_count    (o_entry_count),
        .o_priority_count (o_priority_count)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block: ordered tags, priority ones at the front
    logic [31:0] shadow_tags[$];
    int          shadow_prio = 0;

    tcpq_pkg::t_req    pending_reqs[$];
    tcpq_pkg::t_result expected_results[$];
    tcpq_pkg::t_req    cur_req;
    int                fail_count = 0;
    int                burst_left = 0;
    int                gap_left = 0;

    // Apply one request word to the shadow queue and return its result word
    function automatic tcpq_pkg::t_result queue_update(tcpq_pkg::t_req rq);
        tcpq_pkg::t_result res;
        int slot;
        res.status = tcpq_pkg::STAT_OK;
        res.popped_tag = '0;
        case (rq.req_type)
            tcpq_pkg::REQ_ADD: begin
                if (shadow_tags.size() >= QUEUE_DEPTH) begin
                    res.status = tcpq_pkg::STAT_FULL;
                end else begin
                    slot = rq.is_priority ? shadow_prio : shadow_tags.size();
                    shadow_tags.insert(slot, rq.entry_tag);
                    if (rq.is_priority) shadow_prio++;
                end
            end
            tcpq_pkg::REQ_POP: begin
                if (shadow_tags.size() == 0) begin
                    res.status = tcpq_pkg::STAT_EMPTY;
                end else begin
                    res.popped_tag = shadow_tags[0];
                    shadow_tags.delete(0);
                    if (shadow_prio > 0) shadow_prio--;
                end
            end
            tcpq_pkg::REQ_REMOVE: begin
                if (rq.position < 1 || rq.position > shadow_tags.size()) begin
                    res.status = tcpq_pkg::STAT_NO_POS;
                end else begin
                    slot = int'(rq.position) - 1;
                    shadow_tags.delete(slot);
                    if (slot < shadow_prio) shadow_prio--;
                end
            end
            default: ;
        endcase
        res.entry_count = 5'(shadow_tags.size());
        res.priority_count = 5'(shadow_prio);
        return res;
    endfunction

    function automatic tcpq_pkg::t_req make_req(logic [1:0] kind, logic [31:0] tag,
                                                logic prio, logic [4:0] pos);
        tcpq_pkg::t_req rq;
        rq.req_type = kind;
        rq.entry_tag = tag;
        rq.is_priority = prio;
        rq.position = pos;
        return rq;
    endfunction

    // Append one word to the list waiting for the driver
    function automatic void queue_req(tcpq_pkg::t_req rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    // Random word; add_pct and pop_pct steer the fill level of the queue
    function automatic tcpq_pkg::t_req random_req(int add_pct, int pop_pct);
        tcpq_pkg::t_req rq;
        int roll;
        int tag_roll;
        roll = $urandom_range(0, 99);
        tag_roll = $urandom_range(0, 19);
        rq.entry_tag = (tag_roll == 0) ? 32'h0000_0000 :
                       (tag_roll == 1) ? 32'hFFFF_FFFF : $urandom;
        rq.is_priority = 1'($urandom_range(0, 1));
        rq.position = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, QUEUE_DEPTH));
        if (roll < 3) rq.req_type = REQ_RESERVED;
        else if (roll < 3 + add_pct) rq.req_type = tcpq_pkg::REQ_ADD;
        else if (roll < 3 + add_pct + pop_pct) rq.req_type = tcpq_pkg::REQ_POP;
        else rq.req_type = tcpq_pkg::REQ_REMOVE;
        return rq;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endfunction

    // Stimulus: directed corners, then random phases that fill and drain
    initial begin
        int i;
        int add_pct;
        int pop_pct;
        queue_req(make_req(tcpq_pkg::REQ_POP, 32'h1234_5678, 1'b1, 5'd31));
        queue_req(make_req(tcpq_pkg::REQ_REMOVE, 32'h0, 1'b0, 5'd0));
        queue_req(make_req(tcpq_pkg::REQ_REMOVE, 32'h0, 1'b0, 5'd1));
        queue_req(make_req(REQ_RESERVED, 32'hFFFF_FFFF, 1'b1, 5'd16));
        queue_req(make_req(tcpq_pkg::REQ_ADD, 32'h0000_0000, 1'b0, 5'd0));
        queue_req(make_req(tcpq_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b0, 5'd31));
        queue_req(make_req(tcpq_pkg::REQ_ADD, 32'hA5A5_5A5A, 1'b1, 5'd0));
        queue_req(make_req(tcpq_pkg::REQ_ADD, 32'h5A5A_A5A5, 1'b1, 5'd0));
        // Fill to the last slot with a mix of both classes
        for (i = 0; i < QUEUE_DEPTH - 4; i++)
            queue_req(make_req(tcpq_pkg::REQ_ADD, 32'h100 + i, i[0], 5'd0));
        queue_req(make_req(tcpq_pkg::REQ_ADD, 32'hDEAD_BEEF, 1'b0, 5'd0));
        queue_req(make_req(tcpq_pkg::REQ_ADD, 32'hCAFE_F00D, 1'b1, 5'd0));
        queue_req(make_req(tcpq_pkg::REQ_REMOVE, 32'h0, 1'b0, 5'd16));
        queue_req(make_req(tcpq_pkg::REQ_REMOVE, 32'h0, 1'b0, 5'd16));
        queue_req(make_req(tcpq_pkg::REQ_REMOVE, 32'h0, 1'b1, 5'd2));
        queue_req(make_req(tcpq_pkg::REQ_POP, 32'h0, 1'b0, 5'd0));
        queue_req(make_req(REQ_RESERVED, 32'h0, 1'b0, 5'd0));

        add_pct = 50;
        pop_pct = 25;
        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin add_pct = 75; pop_pct = 12; end
                    1: begin add_pct = 15; pop_pct = 50; end
                    default: begin add_pct = 45; pop_pct = 27; end
                endcase
            end
            queue_req(random_req(add_pct, pop_pct));
        end
    end

    // Reset
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request driver: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.insert(expected_results.size(), queue_update(cur_req));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs[0];
                    pending_reqs.delete(0);
                    i_req_type <= cur_req.req_type;
                    i_entry_tag <= cur_req.entry_tag;
                    i_is_priority <= cur_req.is_priority;
                    i_position <= cur_req.position;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: modes redrawn at random, two long hold-offs
    int stall_cycle = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 150 == 0) stall_mode = $urandom_range(0, 3);
        if ((stall_cycle >= 400 && stall_cycle < 520) ||
            (stall_cycle >= 1500 && stall_cycle < 1600)) begin
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 4) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= stall_cycle[1];
            endcase
        end
    end

    // Result monitor: compare each taken word with the oldest expectation
    always @(posedge i_clk) begin
        tcpq_pkg::t_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual status %0h",
                         $time, o_status);
                fail_count++;
            end else begin
                exp_res = expected_results[0];
                expected_results.delete(0);
                check_field("status", 32'(exp_res.status), 32'(o_status));
                check_field("popped_tag", exp_res.popped_tag, o_popped_tag);
                check_field("entry_count", 32'(exp_res.entry_count), 32'(o_entry_count));
                check_field("priority_count", 32'(exp_res.priority_count),
                            32'(o_priority_count));
            end
        end
    end

    // End of run: all words sent, all results drained, then idle before the report
    initial begin
        int waited;
        @(posedge i_rst_n);
        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        waited = 0;
        while (expected_results.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_results.size() > 0) begin
            $display("%0t: results outstanding, expected 0 actual %0d", $time,
                     expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
